// File: hdl/mmrb_pkg.sv
// shared types and constants for the memory map region builder
`default_nettype none
package mmrb_pkg;

  // firmware type code of free usable memory
  localparam logic [31:0] TYPE_FREE = 32'd1;
  // reset value of the free-space floor register
  localparam logic [31:0] FLOOR_RESET = 32'h0080_0000;
  // register index decoded from paddr[2]
  localparam logic REG_IDX_FLOOR = 1'b0;

  // one incoming memory-map entry
  typedef struct packed {
    logic        start_of_map;
    logic [63:0] entry_base;
    logic [63:0] entry_length;
    logic [31:0] entry_type;
  } entry_t;

  // one emitted region
  typedef struct packed {
    logic [31:0] region_base;
    logic [31:0] region_size;
    logic        region_reserved;
    logic [5:0]  region_number;
    logic        table_full;
    logic        last_of_run;
  } region_t;

  // classified entry handed from front to back
  typedef struct packed {
    logic        is_region;
    logic        start;
    logic [31:0] b32;
    logic [31:0] first_base;
    logic [31:0] first_size;
    logic [31:0] free_base;
    logic [31:0] free_size;
  } cmd_t;

  // back end phase within one entry
  typedef enum logic {
    PH_HEAD,
    PH_FREE
  } phase_t;

endpackage
`default_nettype wire

// File: hdl/mmrb_fifo.sv
// small register fifo used between the stages
`default_nettype none
module mmrb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic                  empty,
  output logic [WIDTH-1:0]      rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr + PW'(1));
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr + PW'(1));
      end
      if (do_push && !do_pop) begin
        count <= CW'(count + CW'(1));
      end else if (do_pop && !do_push) begin
        count <= CW'(count - CW'(1));
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/mmrb_front.sv
// front end: accepts entries, filters them and precomputes free regions
`default_nettype none
module mmrb_front #(
  parameter int PAGE_BYTES = 4096
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [31:0]    floor_addr,
  input  wire mmrb_pkg::entry_t item,
  input  wire logic           push,
  output logic                full,
  output mmrb_pkg::cmd_t      cmd,
  output logic                cmd_push,
  input  wire logic           cmd_full
);
  import mmrb_pkg::*;

  localparam logic [31:0] PMASK = 32'(PAGE_BYTES - 1);
  localparam logic [31:0] PAGE  = 32'(PAGE_BYTES);

  logic        past_limit;
  logic        limit_eff;
  logic        accept;
  logic        base_high;
  logic [64:0] entry_end;
  logic        clip;
  logic [31:0] b32;
  logic [31:0] l32;
  logic [31:0] fit;
  logic [31:0] first_max;
  logic [31:0] first_base;
  logic [31:0] first_span;
  logic [31:0] free_base;
  logic        keep;

  // bytes of whole pages left of s bytes at b once b is aligned up
  function automatic logic [31:0] fit_pages(input logic [31:0] b, input logic [31:0] s);
    logic [31:0] loss;
    loss = (~b + 32'd1) & PMASK;
    if (s < PAGE) begin
      fit_pages = '0;
    end else begin
      fit_pages = (s - loss) & ~PMASK;
    end
  endfunction

  assign full      = cmd_full;
  assign accept    = push && !cmd_full;
  assign limit_eff = item.start_of_map ? 1'b0 : past_limit;
  assign base_high = (item.entry_base[63:32] != '0);
  assign b32       = item.entry_base[31:0];
  assign l32       = item.entry_length[31:0];

  // exact entry end and clipping at 4 GiB
  assign entry_end = {1'b0, item.entry_base} + {1'b0, item.entry_length};
  assign clip      = (entry_end[64:32] != '0);

  // filter
  assign fit  = fit_pages(b32, l32);
  assign keep = !limit_eff && !base_high && (item.entry_type == TYPE_FREE) &&
                !(entry_end < {33'd0, floor_addr}) && !(fit < PAGE);

  // first region of a map
  assign first_max  = (b32 > floor_addr) ? b32 : floor_addr;
  assign first_base = (first_max + PMASK) & ~PMASK;
  assign first_span = b32 + l32 - first_base;

  // free region of a later entry
  assign free_base = (b32 + PMASK) & ~PMASK;

  // command to the back end
  always_comb begin
    cmd.is_region  = keep;
    cmd.start      = item.start_of_map;
    cmd.b32        = b32;
    cmd.first_base = first_base;
    cmd.first_size = (first_span < PAGE) ? '0 : (first_span & ~PMASK);
    cmd.free_base  = free_base;
    cmd.free_size  = clip ? (~free_base + 32'd1) : fit;
  end

  assign cmd_push = accept && (keep || item.start_of_map);

  // stop flag for bases at or above 4 GiB
  always_ff @(posedge clk) begin
    if (rst) begin
      past_limit <= 1'b0;
    end else if (accept) begin
      past_limit <= limit_eff || base_high;
    end
  end

endmodule
`default_nettype wire

// File: hdl/mmrb_back.sv
// back end: counts table regions, emits one per cycle unless stalled
`default_nettype none
module mmrb_back #(
  parameter int MAX_REGIONS = 64
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire mmrb_pkg::cmd_t cmd,
  input  wire logic           cmd_valid,
  output logic                cmd_pop,
  output mmrb_pkg::region_t   result,
  output logic                out_push,
  input  wire logic           out_full
);
  import mmrb_pkg::*;

  localparam int RW = $clog2(MAX_REGIONS + 1);

  phase_t        phase;
  phase_t        phase_next;
  logic [RW-1:0] regions_written;
  logic [RW-1:0] regions_written_next;
  logic [31:0]   previous_region_end;
  logic [31:0]   previous_region_end_next;
  logic [RW-1:0] rw_eff;
  logic [31:0]   pe_eff;
  logic          step;
  logic          table_full;
  logic          is_gap;

  assign step       = cmd_valid && !out_full;
  assign rw_eff     = (phase == PH_HEAD && cmd.start) ? '0 : regions_written;
  assign pe_eff     = (phase == PH_HEAD && cmd.start) ? '0 : previous_region_end;
  assign table_full = (rw_eff >= RW'(MAX_REGIONS));
  assign is_gap     = (phase == PH_HEAD) && (rw_eff != '0);

  // next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_HEAD: begin
        if (step && cmd.is_region && rw_eff != '0) begin
          phase_next = PH_FREE;
        end
      end
      PH_FREE: begin
        if (step) begin
          phase_next = PH_HEAD;
        end
      end
      default: phase_next = PH_HEAD;
    endcase
  end

  // result and queue control
  always_comb begin
    out_push               = 1'b0;
    cmd_pop                = 1'b0;
    result.region_base     = cmd.free_base;
    result.region_size     = cmd.free_size;
    result.region_reserved = 1'b0;
    result.region_number   = 6'(rw_eff);
    result.table_full      = table_full;
    result.last_of_run     = 1'b1;
    unique case (phase)
      PH_HEAD: begin
        if (step) begin
          if (!cmd.is_region) begin
            cmd_pop = 1'b1;
          end else if (rw_eff == '0) begin
            out_push = 1'b1;
            cmd_pop  = 1'b1;
          end else begin
            out_push = 1'b1;
          end
        end
        if (rw_eff == '0) begin
          result.region_base = cmd.first_base;
          result.region_size = cmd.first_size;
        end else begin
          result.region_base     = pe_eff;
          result.region_size     = cmd.b32 - pe_eff;
          result.region_reserved = 1'b1;
          result.last_of_run     = 1'b0;
        end
      end
      PH_FREE: begin
        if (step) begin
          out_push = 1'b1;
          cmd_pop  = 1'b1;
        end
      end
      default: begin
        out_push = 1'b0;
        cmd_pop  = 1'b0;
      end
    endcase
  end

  // table count and end of last stored region
  always_comb begin
    regions_written_next     = regions_written;
    previous_region_end_next = previous_region_end;
    if (step) begin
      regions_written_next     = rw_eff;
      previous_region_end_next = pe_eff;
      if (out_push && !table_full) begin
        regions_written_next     = RW'(rw_eff + RW'(1));
        previous_region_end_next = is_gap ? cmd.b32 :
                                   (result.region_base + result.region_size);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= PH_HEAD;
      regions_written     <= '0;
      previous_region_end <= '0;
    end else begin
      phase               <= phase_next;
      regions_written     <= regions_written_next;
      previous_region_end <= previous_region_end_next;
    end
  end

  // the count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    regions_written <= RW'(MAX_REGIONS))
    else $error("region count above table size");

  // the second half of an entry keeps its command at the queue head
  a_free_has_cmd: assert property (@(posedge clk) disable iff (rst)
    phase == PH_FREE |-> cmd_valid)
    else $error("free phase without a command");

  // the last region of a run retires its command
  a_last_pops: assert property (@(posedge clk) disable iff (rst)
    out_push && result.last_of_run |-> cmd_pop)
    else $error("last region without command pop");

  // a region command is never dropped without output
  a_region_emits: assert property (@(posedge clk) disable iff (rst)
    cmd_pop && cmd.is_region |-> out_push)
    else $error("region command retired silently");

endmodule
`default_nettype wire

// File: hdl/memory_map_region_builder_top.sv
// top level of the memory map region builder
// Memory-map entries are pushed one per cycle while the command queue is not
// full into a front end that filters them and precomputes the aligned free
// region; a four-deep command queue feeds a back end that keeps the region
// table count and emits one region per cycle, while the result queue is not
// full, into a two-deep result queue. A first kept map entry yields one region,
// each later one two (gap region, then free region), and the back end takes
// the next entry only once both regions of the last are written. Skipped entries
// reach the back end only if they open a new map. Each region is registered
// in both queues before it appears. The free-space floor resets to 0x0080_0000.
`default_nettype none
module memory_map_region_builder_top #(
  parameter int MAX_REGIONS = 64,
  parameter int PAGE_BYTES  = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mmrb_pkg::entry_t  item,
  input  wire logic              push,
  output logic                   full,
  output mmrb_pkg::region_t      region,
  output logic                   empty,
  input  wire logic              pop,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import mmrb_pkg::*;

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(region_t);

  logic [31:0]      free_space_floor;
  cmd_t             front_cmd;
  logic             front_cmd_push;
  logic             cmd_full;
  logic [CMD_W-1:0] cmd_bits;
  cmd_t             head_cmd;
  logic             cmd_empty;
  logic             cmd_pop;
  region_t          back_result;
  logic             out_push;
  logic             out_full;
  logic [RES_W-1:0] out_bits;

  // configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      free_space_floor <= FLOOR_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_IDX_FLOOR) begin
      free_space_floor <= pwdata;
    end
  end
  assign prdata = (paddr[2] == REG_IDX_FLOOR) ? free_space_floor : '0;

  // entry filter
  mmrb_front #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .floor_addr(free_space_floor),
    .item      (item),
    .push      (push),
    .full      (full),
    .cmd       (front_cmd),
    .cmd_push  (front_cmd_push),
    .cmd_full  (cmd_full)
  );

  // command queue
  mmrb_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(4)
  ) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (front_cmd_push),
    .full (cmd_full),
    .wdata(CMD_W'(front_cmd)),
    .pop  (cmd_pop),
    .empty(cmd_empty),
    .rdata(cmd_bits)
  );
  assign head_cmd = cmd_t'(cmd_bits);

  // region emitter
  mmrb_back #(
    .MAX_REGIONS(MAX_REGIONS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd      (head_cmd),
    .cmd_valid(!cmd_empty),
    .cmd_pop  (cmd_pop),
    .result   (back_result),
    .out_push (out_push),
    .out_full (out_full)
  );

  // result queue
  mmrb_fifo #(
    .WIDTH(RES_W),
    .DEPTH(2)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (out_push),
    .full (out_full),
    .wdata(RES_W'(back_result)),
    .pop  (pop),
    .empty(empty),
    .rdata(out_bits)
  );
  assign region = region_t'(out_bits);

endmodule
`default_nettype wire
